// File: design/idm_pkg.sv
`default_nettype none
package idm_pkg;

  localparam int unsigned AxisW    = 8;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned SumW     = 10;
  localparam int unsigned QuietW   = 17;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [QuietW-1:0] QuietMax = {QuietW{1'b1}};

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_DEADBAND      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACT_THRESHOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_EXIT_THRESH   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_TIMEOUT  = 2'd3;

  // register reset values
  localparam logic [AxisW-1:0]    DeadbandRst    = 8'd2;
  localparam logic [SumW-1:0]     ActThreshRst   = 10'd80;
  localparam logic [SumW-1:0]     ExitThreshRst  = 10'd60;
  localparam logic [TimeoutW-1:0] IdleTimeoutRst = 16'd36000;

  // item function codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    EVT_NONE       = 2'd0,
    EVT_ENTER_IDLE = 2'd1,
    EVT_EXIT_IDLE  = 2'd2
  } idm_event_e;

  typedef logic [AxisW-1:0] axis_t;

  // settings shared by the decision logic
  typedef struct packed {
    logic [SumW-1:0]     act_threshold;
    logic [SumW-1:0]     exit_threshold;
    logic [TimeoutW-1:0] idle_timeout;
  } idm_thresh_t;

  // outcome of one evaluated tick
  typedef struct packed {
    idm_event_e        evt;
    logic [SumW-1:0]   sum;
    logic [QuietW-1:0] quiet_d;
    logic [SumW-1:0]   prev_sum_d;
  } idm_decision_t;

endpackage
`default_nettype wire

// File: design/idm_if.sv
`default_nettype none
interface idm_in_if
  import idm_pkg::*;
  ();
  logic  valid;
  logic  ready;
  logic  func;
  axis_t accel_x;
  axis_t accel_y;
  axis_t accel_z;
  logic  idle_now;

  modport source (output valid, func, accel_x, accel_y, accel_z, idle_now, input ready);
  modport sink   (input valid, func, accel_x, accel_y, accel_z, idle_now, output ready);
endinterface

interface idm_out_if
  import idm_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [1:0]      event_res;
  logic [SumW-1:0] activity_sum;

  modport source (output valid, event_res, activity_sum, input ready);
  modport sink   (input valid, event_res, activity_sum, output ready);
endinterface
`default_nettype wire

// File: design/accel_idle_motion_detector.sv
// Accelerometer idle/motion detector.
// Input channel in_i carries one beat per half-second tick (func = tick,
// with a signed 3-axis sample and the system idle flag) or a clear command
// (func = clear) that zeroes the quiet counter. Every input beat yields
// exactly one beat on out_o: event_res (none, enter idle, exit idle) and
// activity_sum, which is zero for clear beats and for the skipped second
// tick of each pair.
// Configuration: cfg_we_i, cfg_idx_i and cfg_data_i write deadband,
// activity threshold, exit threshold and idle timeout, one per cycle.
// Write only while no beat is in flight.
// The three axis lanes, the sum and the decision settle within the accepting
// cycle and land in the output register.
// Throughput is one beat per cycle; the output register is the only stage.
// If the receiver stalls, the result is held and in_i.ready drops until the
// held beat is taken. Reset restores the default register values, clears
// the quiet counter, previous sum and previous sample, and re-arms seeding
// so that the first evaluated sample gives zero motion.
`default_nettype none
module accel_idle_motion_detector
  import idm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  idm_in_if.sink                   in_i,
  idm_out_if.source                out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  axis_t             deadband_q;
  idm_thresh_t       thresh_q;
  logic              phase_q;
  logic              seed_q;
  axis_t             prev_q [NumAxes];
  logic [QuietW-1:0] quiet_q;
  logic [SumW-1:0]   prev_sum_q;

  logic              out_valid_q;
  idm_event_e        out_evt_q;
  logic [SumW-1:0]   out_sum_q;

  axis_t             cur [NumAxes];
  axis_t             motion [NumAxes];
  idm_decision_t     dec;
  logic              accept;
  logic              eval;

  assign cur[0] = in_i.accel_x;
  assign cur[1] = in_i.accel_y;
  assign cur[2] = in_i.accel_z;

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    idm_lane u_lane (
      .prev_i     (prev_q[g]),
      .cur_i      (cur[g]),
      .seed_i     (seed_q),
      .deadband_i (deadband_q),
      .motion_o   (motion[g])
    );
  end

  idm_merge u_merge (
    .motion_i     (motion),
    .idle_now_i   (in_i.idle_now),
    .thresh_i     (thresh_q),
    .quiet_q_i    (quiet_q),
    .prev_sum_q_i (prev_sum_q),
    .dec_o        (dec)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign eval       = (in_i.func == FUNC_TICK) && !phase_q;

  assign out_o.valid        = out_valid_q;
  assign out_o.event_res    = out_evt_q;
  assign out_o.activity_sum = out_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q              <= DeadbandRst;
      thresh_q.act_threshold  <= ActThreshRst;
      thresh_q.exit_threshold <= ExitThreshRst;
      thresh_q.idle_timeout   <= IdleTimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEADBAND:      deadband_q              <= cfg_data_i[AxisW-1:0];
        CFG_ACT_THRESHOLD: thresh_q.act_threshold  <= cfg_data_i[SumW-1:0];
        CFG_EXIT_THRESH:   thresh_q.exit_threshold <= cfg_data_i[SumW-1:0];
        CFG_IDLE_TIMEOUT:  thresh_q.idle_timeout   <= cfg_data_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 1'b0;
      seed_q     <= 1'b1;
      prev_q     <= '{default: '0};
      quiet_q    <= '0;
      prev_sum_q <= '0;
    end else if (accept) begin
      if (in_i.func == FUNC_CLEAR) begin
        quiet_q <= '0;
      end else if (phase_q) begin
        phase_q <= 1'b0;
      end else begin
        phase_q    <= 1'b1;
        seed_q     <= 1'b0;
        prev_q     <= cur;
        quiet_q    <= dec.quiet_d;
        prev_sum_q <= dec.prev_sum_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload: load on every accepted beat, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_evt_q <= eval ? dec.evt : EVT_NONE;
      out_sum_q <= eval ? dec.sum : '0;
    end
  end

endmodule
`default_nettype wire

// File: design/idm_lane.sv
`default_nettype none
module idm_lane
  import idm_pkg::*;
(
  input  axis_t prev_i,
  input  axis_t cur_i,
  input  logic  seed_i,
  input  axis_t deadband_i,
  output axis_t motion_o
);

  logic signed [AxisW:0] prev_ext;
  logic signed [AxisW:0] cur_ext;
  logic signed [AxisW:0] diff;
  logic        [AxisW:0] mag;

  // on the seeding tick the previous sample equals the current one
  always_comb begin
    prev_ext = seed_i ? {cur_i[AxisW-1], cur_i} : {prev_i[AxisW-1], prev_i};
    cur_ext  = {cur_i[AxisW-1], cur_i};
    diff     = cur_ext - prev_ext;
    mag      = diff[AxisW] ? (~diff + 1'b1) : diff;
    motion_o = (mag[AxisW-1:0] < deadband_i) ? '0 : mag[AxisW-1:0];
  end

endmodule
`default_nettype wire

// File: design/idm_merge.sv
`default_nettype none
module idm_merge
  import idm_pkg::*;
(
  input  axis_t             motion_i [NumAxes],
  input  logic              idle_now_i,
  input  idm_thresh_t       thresh_i,
  input  logic [QuietW-1:0] quiet_q_i,
  input  logic [SumW-1:0]   prev_sum_q_i,
  output idm_decision_t     dec_o
);

  logic [SumW-1:0]   sum;
  logic [QuietW-1:0] quiet_inc;

  always_comb begin
    sum = {{(SumW-AxisW){1'b0}}, motion_i[0]}
        + {{(SumW-AxisW){1'b0}}, motion_i[1]}
        + {{(SumW-AxisW){1'b0}}, motion_i[2]};
    quiet_inc = (quiet_q_i == QuietMax) ? quiet_q_i : quiet_q_i + 1'b1;

    dec_o.evt        = EVT_NONE;
    dec_o.sum        = sum;
    dec_o.quiet_d    = quiet_q_i;
    dec_o.prev_sum_d = prev_sum_q_i;

    if (!idle_now_i) begin
      dec_o.quiet_d = quiet_inc;
      if (sum < thresh_i.act_threshold) begin
        if (quiet_inc > {1'b0, thresh_i.idle_timeout}) begin
          dec_o.quiet_d = '0;
          dec_o.evt     = EVT_ENTER_IDLE;
        end
      end else begin
        dec_o.quiet_d = '0;
      end
    end else begin
      if ((prev_sum_q_i > thresh_i.act_threshold) && (sum > thresh_i.exit_threshold)) begin
        dec_o.evt = EVT_EXIT_IDLE;
      end
      dec_o.prev_sum_d = sum;
    end
  end

endmodule
`default_nettype wire
